// ===== hdl/newline_checkpoint_indexer_assert.svh =====
// Assertion macros shared by the newline checkpoint indexer modules.
`ifndef NEWLINE_CHECKPOINT_INDEXER_ASSERT_SVH
`define NEWLINE_CHECKPOINT_INDEXER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define NCI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nci check failed");

// Next-cycle implication.
`define NCI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nci check failed");

`endif

// ===== hdl/nci_pkg.sv =====
// Package: widths, constants, types and saturating add for the checkpoint indexer.
`timescale 1ns / 1ps
package nci_pkg;

    localparam int LANES    = 8;
    localparam int NLANES   = (LANES < 8) ? LANES : 8;
    localparam int CNT_W    = $clog2(NLANES + 1);
    localparam int CNT_IN_W = 4;
    localparam int VW       = 40;

    localparam int S_TDATA_W = 72;   // 64 data + 4 count, padded to bytes
    localparam int M_TDATA_W = 160;  // four 40-bit fields

    typedef logic [VW-1:0]    t_val;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_val        MAX_VAL      = '1;
    localparam t_val        MIN_INTERVAL = 40'd8;
    localparam t_val        RST_INTERVAL = 40'd65536;
    localparam logic [7:0]  NEWLINE      = 8'h0A;

    typedef enum logic [1:0] {
        CFG_INTERVAL   = 2'd0,
        CFG_START_OFF  = 2'd1,
        CFG_START_LINE = 2'd2
    } t_cfg_idx;

    // per-lane finding; also the merged selection
    typedef struct packed {
        logic hit;
        t_val line;
        t_val off;
        t_val nso;
    } t_lane_res;

    typedef struct packed {
        logic cp_vld;
        t_val cp_line;
        t_val cp_off;
        t_val lines;
        t_val bytes;
        logic done;
    } t_result;

    function automatic t_val sat_add(input t_val a, input t_val b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VW] ? MAX_VAL : s[VW-1:0];
    endfunction

endpackage

// ===== hdl/newline_checkpoint_indexer.sv =====
// Top level: newline counter with sparse line checkpoints over 8-byte words.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata, tlast
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata, tuser, tlast
//  cfg       in   i_cfg_we (no wait)              i_cfg_idx, i_cfg_wdata
//
// One word per cycle sustained while m_axis_tready is high; each result is registered in the output buffer.
// Line/position/sample state updates across all byte lanes at once for each accepted word.
// Reset (synchronous): interval 65536, start offset 0, start line 0.
// A downstream stall is absorbed by one skid entry; s_axis_tready then drops.
// A write to one of the three registers and every last word reload the scan state.
`timescale 1ns / 1ps
`include "newline_checkpoint_indexer_assert.svh"
module newline_checkpoint_indexer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [nci_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // data_bytes[63:0], byte_count[67:64]
    input  logic                           s_axis_tlast,  // last_word
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [nci_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // checkpoint_line, checkpoint_offset,
                                                          // lines_so_far, bytes_scanned
    output logic                           m_axis_tuser,  // checkpoint_valid
    output logic                           m_axis_tlast,  // scan_done
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [nci_pkg::VW-1:0]         i_cfg_wdata
);
    import nci_pkg::*;

    t_val r_interval, n_interval;
    t_val r_start_off, n_start_off;
    t_val r_start_line, n_start_line;
    t_val r_line, n_line;
    t_val r_pos, n_pos;
    t_val r_pos_i, n_pos_i;
    t_val r_nso, n_nso;

    logic              w_acc;
    logic              w_cfg_hit;
    logic [CNT_IN_W-1:0] w_cnt_raw;
    t_cnt              w_n;
    logic [NLANES-1:0] w_nl;
    t_cnt              w_pref [NLANES];
    t_cnt              w_step [NLANES];
    t_lane_res         w_lane [NLANES];
    t_lane_res         w_sel;
    t_val              w_line_step;
    t_val              w_pos_step;
    t_val              w_eff_int;
    t_val              w_rl_nso;
    t_result           w_res;
    t_result           w_out;

    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_cnt_raw = s_axis_tdata[64 +: CNT_IN_W];
    assign w_n       = (w_cnt_raw > CNT_IN_W'(NLANES)) ? t_cnt'(NLANES) : t_cnt'(w_cnt_raw);

    // newline mask and running newline count across lanes
    always_comb begin
        t_cnt acc;
        acc = '0;
        for (int i = 0; i < NLANES; i++) begin
            w_nl[i]   = (s_axis_tdata[8*i +: 8] == NEWLINE) && (t_cnt'(i) < w_n);
            acc       = acc + t_cnt'(w_nl[i]);
            w_pref[i] = acc;
            w_step[i] = t_cnt'(i + 1);
        end
    end

    for (genvar g = 0; g < NLANES; g++) begin : g_lane
        nci_lane u_lane (
            .i_nl     (w_nl[g]),
            .i_step   (w_step[g]),
            .i_prefix (w_pref[g]),
            .i_pos    (r_pos),
            .i_pos_i  (r_pos_i),
            .i_line   (r_line),
            .i_nso    (r_nso),
            .o_res    (w_lane[g])
        );
    end

    nci_merge u_merge (
        .i_lane (w_lane),
        .o_sel  (w_sel)
    );

    assign w_line_step = sat_add(r_line, t_val'(w_pref[NLANES-1]));
    assign w_pos_step  = sat_add(r_pos, t_val'(w_n));

    // config register write
    always_comb begin
        n_interval   = r_interval;
        n_start_off  = r_start_off;
        n_start_line = r_start_line;
        w_cfg_hit    = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INTERVAL: begin
                    n_interval = i_cfg_wdata;
                    w_cfg_hit  = 1'b1;
                end
                CFG_START_OFF: begin
                    n_start_off = i_cfg_wdata;
                    w_cfg_hit   = 1'b1;
                end
                CFG_START_LINE: begin
                    n_start_line = i_cfg_wdata;
                    w_cfg_hit    = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign w_eff_int = (n_interval < MIN_INTERVAL) ? MIN_INTERVAL : n_interval;
    assign w_rl_nso  = sat_add(n_start_off, w_eff_int);

    // scan state
    always_comb begin
        n_line  = r_line;
        n_pos   = r_pos;
        n_pos_i = r_pos_i;
        n_nso   = r_nso;
        if (w_cfg_hit || (w_acc && s_axis_tlast)) begin
            n_line  = n_start_line;
            n_pos   = n_start_off;
            n_pos_i = w_rl_nso;
            n_nso   = w_rl_nso;
        end else if (w_acc) begin
            n_line  = w_line_step;
            n_pos   = w_pos_step;
            n_pos_i = sat_add(r_pos_i, t_val'(w_n));
            n_nso   = w_sel.hit ? w_sel.nso : r_nso;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= RST_INTERVAL;
            r_start_off  <= '0;
            r_start_line <= '0;
            r_line       <= '0;
            r_pos        <= '0;
            r_pos_i      <= RST_INTERVAL;
            r_nso        <= RST_INTERVAL;
        end else begin
            r_interval   <= n_interval;
            r_start_off  <= n_start_off;
            r_start_line <= n_start_line;
            r_line       <= n_line;
            r_pos        <= n_pos;
            r_pos_i      <= n_pos_i;
            r_nso        <= n_nso;
        end
    end

    always_comb begin
        w_res.cp_vld  = w_sel.hit;
        w_res.cp_line = w_sel.line;
        w_res.cp_off  = w_sel.off;
        w_res.lines   = w_line_step;
        w_res.bytes   = w_pos_step;
        w_res.done    = s_axis_tlast;
    end

    nci_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (w_res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {w_out.bytes, w_out.lines, w_out.cp_off, w_out.cp_line};
    assign m_axis_tuser = w_out.cp_vld;
    assign m_axis_tlast = w_out.done;

    `NCI_ASSERT_IMPL(a_pos_i_ahead, 1'b1, r_pos_i >= r_pos)
    `NCI_ASSERT_IMPL(a_cp_bounds, w_sel.hit,
        (w_sel.off <= w_pos_step) && (w_sel.line <= w_line_step))
    `NCI_ASSERT_NEXT(a_last_reload, w_acc && s_axis_tlast,
        (r_line == r_start_line) && (r_pos == r_start_off))

endmodule

// ===== hdl/nci_lane.sv =====
// One byte lane: newline offset, sample compare and candidate line/next sample.
`timescale 1ns / 1ps
module nci_lane (
    input  logic               i_nl,
    input  nci_pkg::t_cnt      i_step,
    input  nci_pkg::t_cnt      i_prefix,
    input  nci_pkg::t_val      i_pos,
    input  nci_pkg::t_val      i_pos_i,
    input  nci_pkg::t_val      i_line,
    input  nci_pkg::t_val      i_nso,
    output nci_pkg::t_lane_res o_res
);
    import nci_pkg::*;

    t_val w_off;

    always_comb begin
        w_off      = sat_add(i_pos, t_val'(i_step));
        o_res.off  = w_off;
        o_res.hit  = i_nl && (w_off >= i_nso);
        o_res.line = sat_add(i_line, t_val'(i_prefix));
        // pos_i already carries the interval, so this is off + interval
        o_res.nso  = sat_add(i_pos_i, t_val'(i_step));
    end

endmodule

// ===== hdl/nci_merge.sv =====
// Merge stage: picks the first lane that hit the sampling offset.
`timescale 1ns / 1ps
module nci_merge (
    input  nci_pkg::t_lane_res i_lane [nci_pkg::NLANES],
    output nci_pkg::t_lane_res o_sel
);
    import nci_pkg::*;

    always_comb begin
        o_sel = '0;
        for (int i = NLANES - 1; i >= 0; i--) begin
            if (i_lane[i].hit) begin
                o_sel = i_lane[i];
            end
        end
    end

endmodule

// ===== hdl/nci_obuf.sv =====
// Output register with skid entry so one more input is taken under a stall before o_ready drops.
`timescale 1ns / 1ps
`include "newline_checkpoint_indexer_assert.svh"
module nci_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  nci_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output nci_pkg::t_result o_data,
    input  logic             i_ready
);
    import nci_pkg::*;

    logic    r_main_vld, n_main_vld;
    logic    r_skid_vld, n_skid_vld;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_acc;

    assign o_ready = !r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_data  = r_main;
    assign w_acc   = i_valid && !r_skid_vld;

    always_comb begin
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        n_main     = r_main;
        n_skid     = r_skid;
        if (!r_main_vld || i_ready) begin
            if (r_skid_vld) begin
                n_main     = r_skid;
                n_main_vld = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_main     = i_data;
                n_main_vld = w_acc;
            end
        end else if (w_acc) begin
            n_skid     = i_data;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    `NCI_ASSERT_IMPL(a_skid_needs_main, r_skid_vld, r_main_vld)
    `NCI_ASSERT_NEXT(a_skid_fill, w_acc && r_main_vld && !i_ready, r_skid_vld)

endmodule

// ===== tb/sv/tb_newline_checkpoint_indexer.sv =====
// Self-checking testbench for the newline checkpoint indexer: directed table, then random documents.
`timescale 1ns / 1ps
module tb_newline_checkpoint_indexer;
    import nci_pkg::*;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          PHASES          = 8;
    localparam int          WORDS_PER_PHASE = 200;
    localparam logic [1:0]  CFG_IDX_NONE    = 2'd3;   // no register behind this index

    typedef struct packed {
        logic vld;
        t_val line;
        t_val off;
        t_val lines;
        t_val bytes;
        logic done;
    } t_cp_rec;

    typedef struct {
        logic        is_cfg;
        logic [1:0]  idx;
        t_val        wval;
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic        typed;
        t_cp_rec     res;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // data_bytes[63:0], byte_count[67:64], zero pad
    logic                 s_axis_tlast;   // last_word
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // checkpoint_line, checkpoint_offset,
                                          // lines_so_far, bytes_scanned
    logic                 m_axis_tuser;   // checkpoint_valid
    logic                 m_axis_tlast;   // scan_done
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_idx;
    t_val                 i_cfg_wdata;

    // hand-typed expectation travels with the word it belongs to
    logic                 fixed_exp_en;
    t_cp_rec              fixed_exp;

    // scan model state and register copies
    t_val    reg_interval, reg_start_off, reg_start_line;
    t_val    line_cnt, byte_pos, next_off;
    t_cp_rec pending_cp[$];

    // directed stimulus table
    t_dir_row dir_tab[$];

    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    newline_checkpoint_indexer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_val clamp_add(input t_val a, input t_val b);
        if (a > MAX_VAL - b) return MAX_VAL;
        return a + b;
    endfunction

    function automatic t_val min_step();
        return (reg_interval < MIN_INTERVAL) ? MIN_INTERVAL : reg_interval;
    endfunction

    function automatic void restart_scan();
        line_cnt = reg_start_line;
        byte_pos = reg_start_off;
        next_off = clamp_add(reg_start_off, min_step());
    endfunction

    function automatic void store_reg(input logic [1:0] idx, input t_val val);
        case (idx)
            CFG_INTERVAL:   reg_interval = val;
            CFG_START_OFF:  reg_start_off = val;
            CFG_START_LINE: reg_start_line = val;
            default:        return;
        endcase
        restart_scan();
    endfunction

    // expected result of one word; advances the model state
    function automatic t_cp_rec scan_word(input logic [63:0] data, input logic [3:0] cnt,
                                          input logic last);
        t_cp_rec r;
        int      n;
        t_val    off;
        r = '0;
        n = (int'(cnt) > NLANES) ? NLANES : int'(cnt);
        for (int i = 0; i < n; i++) begin
            if (data[8*i +: 8] == NEWLINE) begin
                line_cnt = clamp_add(line_cnt, 40'd1);
                off = clamp_add(byte_pos, t_val'(i + 1));
                if (!r.vld && off >= next_off) begin
                    r.vld  = 1'b1;
                    r.line = line_cnt;
                    r.off  = off;
                    next_off = clamp_add(off, min_step());
                end
            end
        end
        byte_pos = clamp_add(byte_pos, t_val'(n));
        r.lines = line_cnt;
        r.bytes = byte_pos;
        r.done  = last;
        if (last) restart_scan();
        return r;
    endfunction

    task automatic check_field(input string what, input t_val want, input t_val got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // model update and checking share one block so their order within an edge is fixed
    always @(posedge i_clk) begin
        t_cp_rec got, want;
        if (!i_rst_n) begin
            reg_interval   = RST_INTERVAL;
            reg_start_off  = '0;
            reg_start_line = '0;
            restart_scan();
            pending_cp.delete();
        end else begin
            if (i_cfg_we) store_reg(i_cfg_idx, i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) begin
                want = scan_word(s_axis_tdata[63:0], s_axis_tdata[67:64], s_axis_tlast);
                pending_cp.insert(pending_cp.size(), fixed_exp_en ? fixed_exp : want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.vld   = m_axis_tuser;
                got.line  = m_axis_tdata[39:0];
                got.off   = m_axis_tdata[79:40];
                got.lines = m_axis_tdata[119:80];
                got.bytes = m_axis_tdata[159:120];
                got.done  = m_axis_tlast;
                if (pending_cp.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, got);
                end else begin
                    want = pending_cp.pop_front();
                    check_field("checkpoint_valid", t_val'(want.vld), t_val'(got.vld));
                    check_field("checkpoint_line", want.line, got.line);
                    check_field("checkpoint_offset", want.off, got.off);
                    check_field("lines_so_far", want.lines, got.lines);
                    check_field("bytes_scanned", want.bytes, got.bytes);
                    check_field("scan_done", t_val'(want.done), t_val'(got.done));
                end
            end
        end
    end

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input logic last,
                             input logic typed, input t_cp_rec res);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cnt, data};
        s_axis_tlast  <= last;
        fixed_exp_en  <= typed;
        fixed_exp     <= res;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold off input until every result has come back
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cp.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // leaves the write enable high; caller lowers it after the last write
    task automatic write_reg(input logic [1:0] idx, input t_val val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    function automatic t_cp_rec scan_res(input logic vld, input t_val line, input t_val off,
                                         input t_val lines, input t_val bytes, input logic done);
        t_cp_rec r;
        r.vld = vld; r.line = line; r.off = off;
        r.lines = lines; r.bytes = bytes; r.done = done;
        return r;
    endfunction

    function automatic t_dir_row word_row(input logic [63:0] data, input logic [3:0] cnt,
                                          input logic last);
        t_dir_row r;
        r = '{default: '0};
        r.data = data; r.cnt = cnt; r.last = last;
        return r;
    endfunction

    function automatic t_dir_row checked_row(input logic [63:0] data, input logic [3:0] cnt,
                                             input logic last, input t_cp_rec res);
        t_dir_row r;
        r = word_row(data, cnt, last);
        r.typed = 1'b1;
        r.res = res;
        return r;
    endfunction

    function automatic t_dir_row reg_row(input logic [1:0] idx, input t_val val);
        t_dir_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1; r.idx = idx; r.wval = val;
        return r;
    endfunction

    // appends one row to the directed table
    function automatic void add_row(input t_dir_row r);
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    function automatic t_val rand40();
        return {8'($urandom_range(255)), 32'($urandom)};
    endfunction

    initial begin
        logic        cfg_on;
        logic [63:0] word;
        logic [3:0]  cnt;
        t_val        ival, soff, sline;
        int          nl_pct;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_INTERVAL;
        i_cfg_wdata   <= '0;
        fixed_exp_en  <= 1'b0;
        fixed_exp     <= '0;

        // reset values: interval 64K, start at offset 0, line 0
        add_row(checked_row(64'h0A, 4'd1, 1'b0, scan_res(0, 0, 0, 1, 1, 0)));
        add_row(checked_row({8{8'h0A}}, 4'd8, 1'b0, scan_res(0, 0, 0, 9, 9, 0)));
        // count above the lane limit clips to eight
        add_row(checked_row('1, 4'd15, 1'b0, scan_res(0, 0, 0, 9, 17, 0)));
        // empty word still answers; end of document
        add_row(checked_row('0, 4'd0, 1'b1, scan_res(0, 0, 0, 9, 17, 1)));
        // zero interval behaves as eight
        add_row(reg_row(CFG_INTERVAL, '0));
        add_row(checked_row({8{8'h0A}}, 4'd8, 1'b0, scan_res(1, 8, 8, 8, 8, 0)));
        add_row(checked_row(64'h0A00_0000_0000_0000, 4'd8, 1'b0,
                            scan_res(1, 9, 16, 9, 16, 0)));
        add_row(checked_row(64'h0A00_0000_0000_0000, 4'd7, 1'b0,
                            scan_res(0, 0, 0, 9, 23, 0)));
        add_row(word_row({8{8'h0A}}, 4'd8, 1'b1));
        // counters run into saturation
        add_row(reg_row(CFG_INTERVAL, MAX_VAL));
        add_row(reg_row(CFG_START_OFF, MAX_VAL - 3));
        add_row(reg_row(CFG_START_LINE, MAX_VAL - 1));
        add_row(checked_row({8{8'h0A}}, 4'd8, 1'b0,
                            scan_res(1, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, 0)));
        add_row(checked_row(64'hFF0A, 4'd2, 1'b0,
                            scan_res(1, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, 0)));
        add_row(checked_row('0, 4'd8, 1'b1,
                            scan_res(0, 0, 0, MAX_VAL, MAX_VAL, 1)));
        // resume mid-document; a write to the unused index must not restart the scan
        add_row(reg_row(CFG_INTERVAL, MIN_INTERVAL));
        add_row(reg_row(CFG_START_OFF, 40'd100));
        add_row(reg_row(CFG_START_LINE, 40'd5));
        add_row(checked_row('0, 4'd8, 1'b0, scan_res(0, 0, 0, 5, 108, 0)));
        add_row(reg_row(CFG_IDX_NONE, MAX_VAL));
        add_row(checked_row(64'h0A, 4'd1, 1'b0, scan_res(1, 6, 109, 6, 109, 0)));
        add_row(word_row(64'h0A11_0A22_0A33_0A44, 4'd12, 1'b0));
        add_row(word_row(64'h0A0A_0000_0A0A_0000, 4'd9, 1'b0));
        add_row(word_row(64'h0123_4567_89AB_CDEF, 4'd8, 1'b1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_on = 1'b0;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                if (!cfg_on) wait_results();
                write_reg(dir_tab[k].idx, dir_tab[k].wval);
                cfg_on = 1'b1;
            end else begin
                if (cfg_on) begin
                    i_cfg_we <= 1'b0;
                    cfg_on = 1'b0;
                end
                send_word(dir_tab[k].data, dir_tab[k].cnt, dir_tab[k].last,
                          dir_tab[k].typed, dir_tab[k].res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_results();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            if (ph == 1) begin
                ival = MIN_INTERVAL; soff = '0; sline = '0;
            end else if (ph == 2) begin
                ival = MAX_VAL; soff = MAX_VAL - t_val'($urandom_range(300)); sline = MAX_VAL;
            end else begin
                case ($urandom_range(4))
                    0: ival = t_val'($urandom_range(7));
                    1: ival = t_val'($urandom_range(200, 9));
                    2: ival = t_val'($urandom_range(5000, 200));
                    3: ival = RST_INTERVAL;
                    default: ival = rand40();
                endcase
                case ($urandom_range(2))
                    0: soff = '0;
                    1: soff = rand40();
                    default: soff = MAX_VAL - t_val'($urandom_range(300));
                endcase
                case ($urandom_range(2))
                    0: sline = '0;
                    1: sline = rand40();
                    default: sline = MAX_VAL - t_val'($urandom_range(50));
                endcase
            end
            nl_pct = $urandom_range(40, 5);
            write_reg(CFG_INTERVAL, ival);
            write_reg(CFG_START_OFF, soff);
            write_reg(CFG_START_LINE, sline);
            if (ph % 2 == 1) write_reg(CFG_IDX_NONE, rand40());
            i_cfg_we <= 1'b0;

            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if (k == WORDS_PER_PHASE / 2) wait_results();
                for (int b = 0; b < 8; b++)
                    word[8*b +: 8] = ($urandom_range(99) < nl_pct) ? NEWLINE
                                                                   : 8'($urandom_range(255));
                cnt = ($urandom_range(9) < 7) ? 4'd8 : 4'($urandom_range(15));
                send_word(word, cnt, $urandom_range(39) == 0, 1'b0, '0);
            end
        end

        wait_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_cp.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nci_pkg.sv
hdl/nci_lane.sv
hdl/nci_merge.sv
hdl/nci_obuf.sv
hdl/newline_checkpoint_indexer.sv
tb/sv/tb_newline_checkpoint_indexer.sv
